### rtl/core/floppy_card_glue_logic_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the floppy card glue logic
// Shared property forms clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef FLOPPY_CARD_GLUE_LOGIC_TOP_MACROS_SVH
`define FLOPPY_CARD_GLUE_LOGIC_TOP_MACROS_SVH

// Same-cycle implication
`define FCGL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fcgl: same-cycle implication violated");

// Next-cycle implication
`define FCGL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fcgl: next-cycle implication violated");

`endif

### rtl/core/fcgl_pkg.sv
// ----------------------------------------------------------------------------
// Floppy card glue logic package
// Request and result types, configuration record and decode constants.
// ----------------------------------------------------------------------------
package fcgl_pkg;

  // Bus event codes
  typedef enum logic [2:0] {
    CMD_SET_ADDR  = 3'd0,
    CMD_MEM_READ  = 3'd1,
    CMD_MEM_WRITE = 3'd2,
    CMD_CRU_READ  = 3'd3,
    CMD_CRU_WRITE = 3'd4,
    CMD_TICK      = 3'd5,
    CMD_IRQ_LEVEL = 3'd6,
    CMD_DRQ_LEVEL = 3'd7
  } cmd_e;

  // Strobe kinds toward the controller chip and the ROM
  typedef enum logic [1:0] {
    ACC_NONE      = 2'd0,
    ACC_FDC_READ  = 2'd1,
    ACC_FDC_WRITE = 2'd2,
    ACC_ROM_READ  = 2'd3
  } acc_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_GENMOD     = 2'd0;
  localparam logic [1:0] CFG_CRU_BASE   = 2'd1;
  localparam logic [1:0] CFG_MOTOR_HOLD = 2'd2;

  // Bit-port bit numbers
  localparam logic [2:0] BIT_CARD_EN = 3'd0;
  localparam logic [2:0] BIT_MOTOR   = 3'd1;
  localparam logic [2:0] BIT_WAIT    = 3'd2;
  localparam logic [2:0] BIT_HEAD    = 3'd3;
  localparam logic [2:0] BIT_DRIVE0  = 3'd4;
  localparam logic [2:0] BIT_DRIVE1  = 3'd5;
  localparam logic [2:0] BIT_DRIVE2  = 3'd6;
  localparam logic [2:0] BIT_SIDE    = 3'd7;

  // Address decode constants
  localparam logic [20:0] WIN_MASK_STD  = 21'h07e000;
  localparam logic [20:0] WIN_VAL_STD   = 21'h074000;
  localparam logic [20:0] WIN_MASK_WIDE = 21'h1fe000;
  localparam logic [20:0] WIN_VAL_WIDE  = 21'h174000;
  localparam logic [12:0] CHIP_MASK     = 13'h1ff1;
  localparam logic [12:0] CHIP_VAL      = 13'h1ff0;

  // Configuration reset values
  localparam logic [15:0] CRU_BASE_RST   = 16'h1100;
  localparam logic [15:0] MOTOR_HOLD_RST = 16'd4230;

  typedef struct packed {
    cmd_e        command;
    logic [20:0] address;
    logic [7:0]  data;
    logic        line_level;
  } item_t;

  typedef struct packed {
    logic        ready_line;
    acc_e        access_kind;
    logic [1:0]  fdc_register;
    logic [12:0] rom_address;
    logic [7:0]  cru_read_data;
    logic        cru_read_valid;
    logic [1:0]  drive_select;
    logic        motor_on;
    logic        side_select;
  } result_t;

  typedef struct packed {
    logic        genmod_mode;
    logic [15:0] cru_base;
    logic [15:0] motor_hold_ticks;
  } cfg_t;

endpackage

### rtl/core/fcgl_engine.sv
// ----------------------------------------------------------------------------
// Floppy card glue engine
// Card state registers and the single-pass decode of one bus request.
// ----------------------------------------------------------------------------
module fcgl_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  fcgl_pkg::item_t  item,
  input  fcgl_pkg::cfg_t   cfg,
  output fcgl_pkg::result_t result
);
  import fcgl_pkg::*;

  logic [20:0] latched_address, latched_address_next;
  logic        in_card_window, in_card_window_next;
  logic        chip_selected, chip_selected_next;
  logic        card_enabled, card_enabled_next;
  logic        wait_enabled, wait_enabled_next;
  logic        motor_bit_last, motor_bit_last_next;
  logic [2:0]  drive_bits, drive_bits_next;
  logic        side_bit, side_bit_next;
  logic        motor_active, motor_active_next;
  logic [15:0] motor_countdown, motor_countdown_next;
  logic        irq_level, irq_level_next;
  logic        drq_level, drq_level_next;
  logic        ready_state, ready_state_next;

  logic        active;
  logic        cru_hit;
  logic        in_window;
  logic        nz;
  logic        recompute;

  // Decode the request and work out the next card state
  always_comb begin
    latched_address_next = latched_address;
    in_card_window_next  = in_card_window;
    chip_selected_next   = chip_selected;
    card_enabled_next    = card_enabled;
    wait_enabled_next    = wait_enabled;
    motor_bit_last_next  = motor_bit_last;
    drive_bits_next      = drive_bits;
    side_bit_next        = side_bit;
    motor_active_next    = motor_active;
    motor_countdown_next = motor_countdown;
    irq_level_next       = irq_level;
    drq_level_next       = drq_level;
    recompute            = 1'b0;

    result                = '0;
    result.access_kind    = ACC_NONE;

    active  = in_card_window && card_enabled;
    cru_hit = (item.address[15:8] == cfg.cru_base[15:8]) && (cfg.cru_base[7:0] == 8'h00);
    in_window = cfg.genmod_mode ? ((item.address & WIN_MASK_WIDE) == WIN_VAL_WIDE)
                                : ((item.address & WIN_MASK_STD) == WIN_VAL_STD);
    nz = (item.data != 8'h00);

    unique case (item.command)
      CMD_SET_ADDR: begin
        latched_address_next = item.address;
        in_card_window_next  = in_window;
        // Chip select only follows a selected address; otherwise it goes stale
        if (in_window && card_enabled) begin
          chip_selected_next = ((item.address[12:0] & CHIP_MASK) == CHIP_VAL);
          recompute          = 1'b1;
        end
      end
      CMD_MEM_READ: begin
        if (active) begin
          if (chip_selected && !latched_address[3] && !latched_address[0]) begin
            result.access_kind  = ACC_FDC_READ;
            result.fdc_register = item.address[2:1];
          end else begin
            result.access_kind = ACC_ROM_READ;
            result.rom_address = latched_address[12:0];
          end
        end
      end
      CMD_MEM_WRITE: begin
        if (active && chip_selected && latched_address[3] && !latched_address[0]) begin
          result.access_kind  = ACC_FDC_WRITE;
          result.fdc_register = item.address[2:1];
        end
      end
      CMD_CRU_READ: begin
        if (cru_hit) begin
          result.cru_read_valid = 1'b1;
          if (item.address[2:0] == 3'b000) begin
            result.cru_read_data = {side_bit, 1'b1, 1'b0, !motor_active, drive_bits, 1'b0};
          end
        end
      end
      CMD_CRU_WRITE: begin
        if (cru_hit) begin
          unique case (item.address[3:1])
            BIT_CARD_EN: card_enabled_next = nz;
            BIT_MOTOR: begin
              // Retrigger the monoflop on a rising motor bit
              if ((item.data == 8'h01) && !motor_bit_last) begin
                motor_active_next    = 1'b1;
                motor_countdown_next = cfg.motor_hold_ticks;
                recompute            = 1'b1;
              end
              motor_bit_last_next = nz;
            end
            BIT_WAIT:   wait_enabled_next  = nz;
            BIT_HEAD:   ;
            BIT_DRIVE0: drive_bits_next[0] = nz;
            BIT_DRIVE1: drive_bits_next[1] = nz;
            BIT_DRIVE2: drive_bits_next[2] = nz;
            BIT_SIDE:   side_bit_next      = (item.data == 8'h01);
            default:    ;
          endcase
        end
      end
      CMD_TICK: begin
        // Count the monoflop down; drop the motor at expiry
        if (motor_active) begin
          if (motor_countdown <= 16'd1) begin
            motor_countdown_next = '0;
            motor_active_next    = 1'b0;
            recompute            = 1'b1;
          end else begin
            motor_countdown_next = motor_countdown - 16'd1;
          end
        end
      end
      CMD_IRQ_LEVEL: begin
        irq_level_next = item.line_level;
        recompute      = 1'b1;
      end
      CMD_DRQ_LEVEL: begin
        drq_level_next = item.line_level;
        recompute      = 1'b1;
      end
      default: ;
    endcase

    // Wait states only while selected, enabled, motor on and no chip request
    ready_state_next = recompute
      ? !(chip_selected_next && wait_enabled_next && !drq_level_next
          && !irq_level_next && motor_active_next)
      : ready_state;

    result.ready_line  = ready_state_next;
    result.motor_on    = motor_active_next;
    result.side_select = side_bit_next;
    priority if (drive_bits_next[2]) result.drive_select = 2'd3;
    else if (drive_bits_next[1])     result.drive_select = 2'd2;
    else if (drive_bits_next[0])     result.drive_select = 2'd1;
    else                             result.drive_select = 2'd0;
  end

  // Commit the state when the request moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      latched_address <= '0;
      in_card_window  <= 1'b0;
      chip_selected   <= 1'b0;
      card_enabled    <= 1'b0;
      wait_enabled    <= 1'b0;
      motor_bit_last  <= 1'b0;
      drive_bits      <= '0;
      side_bit        <= 1'b0;
      motor_active    <= 1'b0;
      motor_countdown <= '0;
      irq_level       <= 1'b0;
      drq_level       <= 1'b0;
      ready_state     <= 1'b1;
    end else if (advance) begin
      latched_address <= latched_address_next;
      in_card_window  <= in_card_window_next;
      chip_selected   <= chip_selected_next;
      card_enabled    <= card_enabled_next;
      wait_enabled    <= wait_enabled_next;
      motor_bit_last  <= motor_bit_last_next;
      drive_bits      <= drive_bits_next;
      side_bit        <= side_bit_next;
      motor_active    <= motor_active_next;
      motor_countdown <= motor_countdown_next;
      irq_level       <= irq_level_next;
      drq_level       <= drq_level_next;
      ready_state     <= ready_state_next;
    end
  end

endmodule

### rtl/core/floppy_card_glue_logic_top.sv
// ----------------------------------------------------------------------------
// Floppy card glue logic, top level
// Bus event decode, card control bits, motor monoflop and READY generation.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (cmd_valid/cmd_stall): one bus event per request with
//   command, address, data and line_level. Taken when cmd_valid is high and
//   cmd_stall is low.
//   Result channel (res_valid/res_stall): exactly one result per request, in
//   order, taken when res_valid is high and res_stall is low.
//   Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data): cfg_ready is
//   always high; index 0 map mode, 1 bit-port base, 2 motor hold ticks.
//   Write it only while no request is in flight.
//   Path: a request taken into the request register is moved into the
//   result register, and res_valid rises, once the result register is empty
//   or its result is being taken; a stalled result holds the request back.
//   Throughput: one request per cycle while no result is stalled, set by the
//   combinational decode and state update between the two registers.
//   Reset (rst, synchronous): clears the card state, sets READY high and
//   restores the configuration defaults; both registers come up empty.
//   Stall: a stalled result holds; the request register still fills behind
//   it, and cmd_stall rises only when both registers are occupied and the
//   result is stalled.
// ----------------------------------------------------------------------------
module floppy_card_glue_logic_top (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [2:0]  command,
  input  logic [20:0] address,
  input  logic [7:0]  data,
  input  logic        line_level,
  // result channel
  output logic        res_valid,
  input  logic        res_stall,
  output logic        ready_line,
  output logic [1:0]  access_kind,
  output logic [1:0]  fdc_register,
  output logic [12:0] rom_address,
  output logic [7:0]  cru_read_data,
  output logic        cru_read_valid,
  output logic [1:0]  drive_select,
  output logic        motor_on,
  output logic        side_select,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import fcgl_pkg::*;

  `include "floppy_card_glue_logic_top_macros.svh"

  item_t   item;
  logic    item_valid;
  result_t res;
  result_t res_next;
  cfg_t    cfg;
  logic    item_load;
  logic    res_load;

  // Handshake control
  assign res_load  = item_valid && (!res_valid || !res_stall);
  assign cmd_stall = item_valid && !res_load;
  assign item_load = cmd_valid && !cmd_stall;
  assign cfg_ready = 1'b1;

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item_load) begin
      item_valid <= 1'b1;
    end else if (res_load) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_load) begin
      item.command    <= cmd_e'(command);
      item.address    <= address;
      item.data       <= data;
      item.line_level <= line_level;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.genmod_mode      <= 1'b0;
      cfg.cru_base         <= CRU_BASE_RST;
      cfg.motor_hold_ticks <= MOTOR_HOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GENMOD:     cfg.genmod_mode      <= cfg_data[0];
        CFG_CRU_BASE:   cfg.cru_base         <= cfg_data;
        CFG_MOTOR_HOLD: cfg.motor_hold_ticks <= cfg_data;
        default:        ;
      endcase
    end
  end

  fcgl_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .advance(res_load),
    .item   (item),
    .cfg    (cfg),
    .result (res_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

  assign ready_line     = res.ready_line;
  assign access_kind    = res.access_kind;
  assign fdc_register   = res.fdc_register;
  assign rom_address    = res.rom_address;
  assign cru_read_data  = res.cru_read_data;
  assign cru_read_valid = res.cru_read_valid;
  assign drive_select   = res.drive_select;
  assign motor_on       = res.motor_on;
  assign side_select    = res.side_select;

  // A pending request must not be dropped while the result is held
  `FCGL_ASSERT_NEXT(a_item_held, item_valid && res_valid && res_stall, item_valid)
  // A bit-port read never strobes memory
  `FCGL_ASSERT_IMP(a_cru_no_strobe, res_valid && cru_read_valid, access_kind == ACC_NONE)
  // Bit-port data only accompanies a hit
  `FCGL_ASSERT_IMP(a_cru_data_zero, res_valid && !cru_read_valid, cru_read_data == 8'h00)
  // ROM address only on a ROM strobe, register index only on a chip strobe
  `FCGL_ASSERT_IMP(a_strobe_fields, res_valid && access_kind == ACC_NONE, fdc_register == 2'd0 && rom_address == 13'd0)

endmodule
